>>> rtl/core/depq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depq_pkg: shared types and codes for the double-ended priority queue
// Holds the item and result beat layouts, the item kinds, the status codes
// and the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package depq_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_CLOSE  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_SINGLE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
    } t_item;

    typedef struct packed {
        logic [31:0] spread;
        logic [63:0] running_total;
        logic [1:0]  status;
    } t_result;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_LAST,
        RD_SRC
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_VALUE,
        WR_RDATA
    } t_wr_sel;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [1:0] status;
        logic       pop;
        logic       flush;
        logic       clr_total;
        logic       ins_done;
        logic       step;
        logic       cap_min;
        t_rd_sel    rd_sel;
        t_wr_sel    wr_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic cnt_zero;
        logic cnt_one;
        logic left_zero;
        logic gt;
    } t_dp_stat;

endpackage

>>> rtl/core/depq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depq_dp: datapath of the double-ended priority queue
// A circular sorted store in one memory, the head and tail pointers, the fill
// count, the insertion shift pointers, the running total and the result beat.
// ----------------------------------------------------------------------------
module depq_dp #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  depq_pkg::t_item   i_item,
    input  depq_pkg::t_dp_cmd i_cmd,
    output depq_pkg::t_dp_stat o_stat,
    output logic              o_done,
    output depq_pkg::t_result o_result
);
    import depq_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(CAPACITY - 1);

    logic [VALUE_BITS-1:0] mem [CAPACITY];

    logic [PW-1:0]         r_head;
    logic [PW-1:0]         r_tail;
    logic [CW-1:0]         r_count;
    logic [63:0]           r_total;
    logic [PW-1:0]         r_dst;
    logic [PW-1:0]         r_src;
    logic [CW-1:0]         r_left;
    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] r_rdata;
    logic [VALUE_BITS-1:0] r_min;
    logic                  r_done;
    t_result               r_result;

    logic [PW-1:0]         head_inc;
    logic [PW-1:0]         tail_inc;
    logic [PW-1:0]         tail_dec;
    logic [PW-1:0]         src_dec;
    logic [PW-1:0]         rd_addr;
    logic [VALUE_BITS-1:0] in_value;
    logic [VALUE_BITS-1:0] diff;
    logic [63:0]           diff_ext;
    logic [64:0]           sum;
    logic [63:0]           sat_sum;

    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign tail_dec = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
    assign src_dec  = (r_src == '0) ? LAST_IDX : r_src - 1'b1;

    // Values wider than the port are zero extended, narrower ones are masked.
    assign in_value = VALUE_BITS'({32'd0, i_item.value});

    assign diff     = r_rdata - r_min;
    assign diff_ext = 64'(diff);
    assign sum      = {1'b0, r_total} + {1'b0, diff_ext};
    assign sat_sum  = sum[64] ? '1 : sum[63:0];

    always_comb begin
        case (i_cmd.rd_sel)
            RD_LAST: rd_addr = tail_dec;
            RD_SRC:  rd_addr = r_src;
            default: rd_addr = r_head;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_addr];
        if (i_cmd.wr_sel == WR_VALUE) begin
            mem[r_dst] <= r_value;
        end else if (i_cmd.wr_sel == WR_RDATA) begin
            mem[r_dst] <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= in_value;
            r_dst   <= r_tail;
            r_src   <= tail_dec;
            r_left  <= r_count;
        end else if (i_cmd.step) begin
            r_dst  <= r_src;
            r_src  <= src_dec;
            r_left <= r_left - 1'b1;
        end
        if (i_cmd.cap_min) begin
            r_min <= r_rdata;
        end
        if (i_cmd.emit) begin
            r_result.status        <= i_cmd.status;
            r_result.spread        <= i_cmd.pop ? diff_ext[31:0] : 32'd0;
            r_result.running_total <= i_cmd.pop ? sat_sum : r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
            if (i_cmd.flush) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
            end else if (i_cmd.pop) begin
                r_head  <= head_inc;
                r_tail  <= tail_dec;
                r_count <= r_count - CW'(2);
            end else if (i_cmd.ins_done) begin
                r_tail  <= tail_inc;
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.clr_total) begin
                r_total <= '0;
            end else if (i_cmd.pop) begin
                r_total <= sat_sum;
            end
        end
    end

    assign o_stat.full      = (r_count == CW'(CAPACITY));
    assign o_stat.cnt_zero  = (r_count == '0);
    assign o_stat.cnt_one   = (r_count == CW'(1));
    assign o_stat.left_zero = (r_left == '0);
    assign o_stat.gt        = (r_rdata > r_value);

    assign o_done   = r_done;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty store with head and tail apart");

    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_cmd.clr_total)) |-> (r_total >= $past(r_total)))
        else $error("running total fell without a clear");

endmodule

>>> rtl/core/depq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depq_ctrl: controller of the double-ended priority queue
// Decodes each accepted item and sequences the insertion shift and the
// two reads of a close-day item.
// ----------------------------------------------------------------------------
module depq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_kind,
    input  depq_pkg::t_dp_stat i_stat,
    output logic               o_busy,
    output depq_pkg::t_dp_cmd  o_cmd
);
    import depq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_CL_MIN,
        S_CL_MAX
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_comb begin
        n_state       = r_state;
        cmd           = '0;
        cmd.rd_sel    = RD_HEAD;
        cmd.wr_sel    = WR_NONE;
        cmd.status    = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    case (i_kind)
                        KIND_INSERT: begin
                            if (i_stat.full) begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_FULL;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        KIND_CLOSE: begin
                            if (i_stat.cnt_zero) begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_EMPTY;
                            end else if (i_stat.cnt_one) begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_SINGLE;
                                cmd.flush  = 1'b1;
                            end else begin
                                n_state = S_CL_MIN;
                            end
                        end
                        KIND_FINISH: begin
                            cmd.emit      = 1'b1;
                            cmd.flush     = 1'b1;
                            cmd.clr_total = 1'b1;
                        end
                        default: begin
                            cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (i_stat.left_zero) begin
                    cmd.wr_sel   = WR_VALUE;
                    cmd.ins_done = 1'b1;
                    cmd.emit     = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    cmd.rd_sel = RD_SRC;
                    n_state    = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.gt) begin
                    cmd.wr_sel = WR_RDATA;
                    cmd.step   = 1'b1;
                    n_state    = S_INS_RD;
                end else begin
                    cmd.wr_sel   = WR_VALUE;
                    cmd.ins_done = 1'b1;
                    cmd.emit     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_CL_MIN: begin
                cmd.cap_min = 1'b1;
                cmd.rd_sel  = RD_LAST;
                n_state     = S_CL_MAX;
            end
            S_CL_MAX: begin
                cmd.pop  = 1'b1;
                cmd.emit = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = cmd;

    a_insert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_kind == KIND_INSERT && !i_stat.full)
        |=> o_busy)
        else $error("insert accepted without entering the shift sequence");

endmodule

>>> rtl/core/double_ended_priority_queue_spread_top.sv
`timescale 1ns / 1ps
// Items that need no store access are answered straight from idle. A close-day
// item with two or more entries reads the smallest and then the largest entry;
// an insert moves each larger entry up by one place, a read and a write each.
// Throughput: one item in work at a time; busy stays high until the result
// beat issues, and the receiver cannot stall it. Synchronous active-low reset
// empties the store and clears the total at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// double_ended_priority_queue_spread_top: double-ended priority queue
// Keeps a sorted multiset of values, removes the largest and smallest on a
// close-day item and accumulates their difference into a saturating total.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_spread_top #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  depq_pkg::t_item   i_item,
    output logic              o_done,
    output depq_pkg::t_result o_result
);
    import depq_pkg::*;

    // The controller decodes each accepted beat and steps through the store
    // accesses; the datapath owns the store and all data registers. They talk only
    // through the command and status bundles below.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The store is a circular buffer kept in ascending order between head and
    // tail. The smallest value sits at head and the largest just below tail,
    // so a close-day item costs two reads. An insert walks down from the tail,
    // moving each larger entry up by one place until the gap is found.
    depq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_item.kind),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // The result beat is registered in the datapath alongside the done strobe
    // and holds its value until the next result beat is issued.
    depq_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
